FILE: rtl/tcect_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcect_pkg
// Shared types and constants for the three-channel end-count timer.
// ----------------------------------------------------------------------------
package tcect_pkg;

  // Defaults for the top-level parameters
  localparam int NumChannelsDef = 3;
  localparam int CountBitsDef   = 32;

  // Register map ceiling: the map always shows three channel slots
  localparam int MaxChannels = 3;
  localparam int SelBits     = 2;
  localparam int DivBits     = 4;
  localparam int CtrlRdBits  = 10;

  // Word kinds
  typedef enum logic [1:0] {
    KIND_TICK  = 2'd0,
    KIND_READ  = 2'd1,
    KIND_WRITE = 2'd2
  } kind_e;

  // Register word offsets
  localparam logic [3:0] OFF_GLOBAL = 4'd2;
  localparam logic [3:0] OFF_END0   = 4'd4;
  localparam logic [3:0] OFF_END1   = 4'd5;
  localparam logic [3:0] OFF_END2   = 4'd6;
  localparam logic [3:0] OFF_CTRL   = 4'd7;
  localparam logic [3:0] OFF_RDCTL  = 4'd8;
  localparam logic [3:0] OFF_RDVAL  = 4'd9;

  // Control-register bit positions
  localparam int CtrlDivLsb  = 3;
  localparam int CtrlPendLsb = 7;
  localparam int RdSelLsb    = 2;

  typedef struct packed {
    logic [1:0]  kind;
    logic [3:0]  word_offset;
    logic [31:0] write_data;
  } in_word_t;

  typedef struct packed {
    logic [31:0] read_data;
    logic        irq_line;
  } out_word_t;

  // Per-channel strobes from the register block
  typedef struct packed {
    logic adv;     // prescaler period done, channel enabled
    logic drop;    // enable cleared by a control write
    logic end_wr;  // end-count register written
  } chan_ctrl_t;

endpackage

FILE: rtl/tcect_chan.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcect_chan
// One up-counter with its end-count register and match detect.
// ----------------------------------------------------------------------------
module tcect_chan #(
  parameter int COUNT_BITS = tcect_pkg::CountBitsDef
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  tcect_pkg::chan_ctrl_t ctrl_i,
  input  logic [COUNT_BITS-1:0] wdata_i,
  output logic [COUNT_BITS-1:0] count_o,
  output logic [COUNT_BITS-1:0] end_count_o,
  output logic                  fire_o
);

  logic [COUNT_BITS-1:0] count_q, count_d;
  logic [COUNT_BITS-1:0] end_q, end_d;
  logic [COUNT_BITS-1:0] inc;

  assign inc    = count_q + 1'b1;
  assign fire_o = ctrl_i.adv && (inc == end_q);

  always_comb begin
    count_d = count_q;
    end_d   = end_q;
    if (ctrl_i.drop) begin
      count_d = '0;
    end else if (ctrl_i.adv) begin
      count_d = fire_o ? '0 : inc;
    end
    if (ctrl_i.end_wr) begin
      end_d = wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      end_q   <= '0;
    end else begin
      count_q <= count_d;
      end_q   <= end_d;
    end
  end

  assign count_o     = count_q;
  assign end_count_o = end_q;

endmodule

FILE: rtl/three_channel_end_count_timer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// three_channel_end_count_timer
// Timer with up to three up-counters, end-count match and W1C pending bits.
// ----------------------------------------------------------------------------
// Each word on the input channel is a clock tick, a bus read or a bus write.
// The block takes one word per cycle while in_stall is low and returns
// exactly one result word per input word once the output is not stalled: the
// word is captured in an input register, decoded and applied to the timer
// state in a single pass, and the result lands in an output register. The
// output register lets a new word enter while an earlier result waits; input
// stall rises only when both registers are full and the output is stalled.
// Counting needs the run bit (offset 2, bit 0); channels then advance once
// every divider+1 ticks. On match with the end count a channel sets its
// pending bit and restarts at zero; irq_line is the OR of the pending bits
// after the word. Reads of a result for ticks and writes return zero.
// ----------------------------------------------------------------------------
module three_channel_end_count_timer #(
  parameter int NUM_CHANNELS = tcect_pkg::NumChannelsDef,
  parameter int COUNT_BITS   = tcect_pkg::CountBitsDef
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  tcect_pkg::in_word_t  in_word_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output tcect_pkg::out_word_t out_word_o
);

  localparam int NCH = tcect_pkg::MaxChannels;

  // -- Pipeline registers ----------------------------------------------------
  logic                 in_vld_q, in_vld_d;
  tcect_pkg::in_word_t  in_q;
  logic                 out_vld_q, out_vld_d;
  tcect_pkg::out_word_t out_q, out_d;
  logic                 proc;   // word in the input register is applied now
  logic                 accept;

  assign proc       = in_vld_q && (!out_vld_q || !out_stall_i);
  assign in_stall_o = in_vld_q && !proc;
  assign accept     = in_valid_i && !in_stall_o;
  assign in_vld_d   = accept || (in_vld_q && !proc);
  assign out_vld_d  = proc || (out_vld_q && out_stall_i);

  // -- Timer state -----------------------------------------------------------
  logic                                 run_q, run_d;
  logic [NUM_CHANNELS-1:0]              en_q, en_d;
  logic [tcect_pkg::DivBits-1:0]        div_q, div_d;
  logic [tcect_pkg::DivBits-1:0]        pre_q, pre_d;
  logic [NUM_CHANNELS-1:0]              pend_q, pend_d;
  logic [tcect_pkg::SelBits-1:0]        sel_q, sel_d;
  logic [COUNT_BITS-1:0]                latch_q, latch_d;

  // -- Decode ----------------------------------------------------------------
  logic is_tick, is_read, is_write;
  logic [3:0]  off;
  logic [31:0] wdata;
  logic        period_done;
  logic [NUM_CHANNELS-1:0] new_en, fire;

  assign is_tick  = proc && (in_q.kind == tcect_pkg::KIND_TICK);
  assign is_read  = proc && (in_q.kind == tcect_pkg::KIND_READ);
  assign is_write = proc && (in_q.kind == tcect_pkg::KIND_WRITE);
  assign off      = in_q.word_offset;
  assign wdata    = in_q.write_data;
  assign new_en   = wdata[NUM_CHANNELS-1:0];

  // prescaler wraps once pre reaches the divider (also when divider lowered)
  assign period_done = is_tick && run_q && (pre_q >= div_q);

  // -- Channels --------------------------------------------------------------
  tcect_pkg::chan_ctrl_t ctl [NUM_CHANNELS];
  logic [COUNT_BITS-1:0] cnt_pad [2**tcect_pkg::SelBits];
  logic [COUNT_BITS-1:0] end_pad [2**tcect_pkg::SelBits];

  for (genvar c = 0; c < 2**tcect_pkg::SelBits; c++) begin : g_chan
    if (c < NUM_CHANNELS) begin : g_on
      assign ctl[c].adv    = period_done && en_q[c];
      assign ctl[c].drop   = is_write && (off == tcect_pkg::OFF_CTRL) &&
                             en_q[c] && !new_en[c];
      assign ctl[c].end_wr = is_write && (off == 4'(tcect_pkg::OFF_END0 + c));

      tcect_chan #(
        .COUNT_BITS (COUNT_BITS)
      ) u_chan (
        .clk_i       (clk_i),
        .rst_ni      (rst_ni),
        .ctrl_i      (ctl[c]),
        .wdata_i     (wdata[COUNT_BITS-1:0]),
        .count_o     (cnt_pad[c]),
        .end_count_o (end_pad[c]),
        .fire_o      (fire[c])
      );
    end else begin : g_off
      // absent channel reads as zero
      assign cnt_pad[c] = '0;
      assign end_pad[c] = '0;
    end
  end

  // -- Next state ------------------------------------------------------------
  logic [tcect_pkg::SelBits-1:0] wr_sel;
  assign wr_sel = wdata[tcect_pkg::RdSelLsb +: tcect_pkg::SelBits];

  always_comb begin
    run_d   = run_q;
    en_d    = en_q;
    div_d   = div_q;
    pre_d   = pre_q;
    pend_d  = pend_q | fire;
    sel_d   = sel_q;
    latch_d = latch_q;
    if (is_tick && run_q) begin
      pre_d = period_done ? '0 : pre_q + 1'b1;
    end
    if (is_write) begin
      case (off)
        tcect_pkg::OFF_GLOBAL: begin
          run_d = wdata[0];
        end
        tcect_pkg::OFF_CTRL: begin
          en_d   = new_en;
          div_d  = wdata[tcect_pkg::CtrlDivLsb +: tcect_pkg::DivBits];
          pend_d = pend_q & ~wdata[tcect_pkg::CtrlPendLsb +: NUM_CHANNELS];
        end
        tcect_pkg::OFF_RDCTL: begin
          sel_d = wr_sel;
          if (wdata[0]) begin
            latch_d = cnt_pad[wr_sel];
          end
        end
        default: ;
      endcase
    end
  end

  // -- Read mux --------------------------------------------------------------
  logic [tcect_pkg::SelBits-1:0]    end_idx;
  logic [tcect_pkg::CtrlRdBits-1:0] ctrl_rd;
  logic [31:0]                      rd;

  assign end_idx = tcect_pkg::SelBits'(off - tcect_pkg::OFF_END0);
  assign ctrl_rd = {NCH'(pend_q), div_q, NCH'(en_q)};

  always_comb begin
    rd = '0;
    if (is_read) begin
      case (off)
        tcect_pkg::OFF_GLOBAL: rd = 32'(run_q);
        tcect_pkg::OFF_END0,
        tcect_pkg::OFF_END1,
        tcect_pkg::OFF_END2:   rd = 32'(end_pad[end_idx]);
        tcect_pkg::OFF_CTRL:   rd = 32'(ctrl_rd);
        tcect_pkg::OFF_RDCTL:  rd = 32'({sel_q, 2'b00});
        tcect_pkg::OFF_RDVAL:  rd = 32'(latch_q);
        default:               rd = '0;
      endcase
    end
  end

  always_comb begin
    out_d           = out_q;
    if (proc) begin
      out_d.read_data = rd;
      out_d.irq_line  = |pend_d;
    end
  end

  // -- Registers -------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
      run_q     <= 1'b0;
      en_q      <= '0;
      div_q     <= '0;
      pre_q     <= '0;
      pend_q    <= '0;
      sel_q     <= '0;
      latch_q   <= '0;
    end else begin
      in_vld_q  <= in_vld_d;
      out_vld_q <= out_vld_d;
      run_q     <= run_d;
      en_q      <= en_d;
      div_q     <= div_d;
      pre_q     <= pre_d;
      pend_q    <= pend_d;
      sel_q     <= sel_d;
      latch_q   <= latch_d;
    end
  end

  // payload, no reset
  always_ff @(posedge clk_i) begin
    if (accept) begin
      in_q <= in_word_i;
    end
    out_q <= out_d;
  end

  assign out_valid_o = out_vld_q;
  assign out_word_o  = out_q;

endmodule

FILE: rtl/tcect_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcect_checker
// Port-level checks for the timer, bound to the top level.
// ----------------------------------------------------------------------------
module tcect_checker (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 in_valid_i,
  input logic                 in_stall_o,
  input tcect_pkg::in_word_t  in_word_i,
  input logic                 out_valid_o,
  input logic                 out_stall_i,
  input tcect_pkg::out_word_t out_word_o
);

  logic in_acc;
  assign in_acc = in_valid_i && !in_stall_o;

  // held result word stays put
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_word_o))
    else $error("result word changed while stalled");

  // input back-pressure only comes from a full, stalled output
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without output back-pressure");

  // an accepted word reaches the output register when the output flows
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc ##1 (!out_valid_o || !out_stall_i) |=> out_valid_o)
    else $error("result missing after accepted word");

  // no result out of an empty block: output idle and nothing taken in
  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_acc && !out_valid_o ##1 !in_acc && !out_valid_o |=> !out_valid_o)
    else $error("result without an accepted word");

endmodule

bind three_channel_end_count_timer tcect_checker u_tcect_checker (.*);
